FILE: rtl/core/napt_pkg.sv
// ----------------------------------------------------------------------------
// napt_pkg
// Shared types and codes of the address-and-port translation table.
// ----------------------------------------------------------------------------
package napt_pkg;

	localparam logic [1:0] FUNC_OUT  = 2'd0;
	localparam logic [1:0] FUNC_IN   = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;
	localparam logic [1:0] FUNC_ADD  = 2'd3;

	localparam logic [1:0] PC_ICMP = 2'd0;
	localparam logic [1:0] PC_UDP  = 2'd1;
	localparam logic [1:0] PC_TCP  = 2'd2;
	localparam logic [1:0] PC_UNK  = 2'd3;

	localparam logic [7:0] PNUM_ICMP = 8'd1;
	localparam logic [7:0] PNUM_UDP  = 8'd17;
	localparam logic [7:0] PNUM_TCP  = 8'd6;

	localparam logic [2:0] ST_TRANSLATED = 3'd0;
	localparam logic [2:0] ST_PASSED     = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND  = 3'd2;
	localparam logic [2:0] ST_FULL       = 3'd3;
	localparam logic [2:0] ST_UNSUPP     = 3'd4;
	localparam logic [2:0] ST_DONE       = 3'd5;

	localparam logic CFG_EXPIRE = 1'b0;
	localparam logic CFG_ENABLE = 1'b1;

	typedef enum logic [2:0] {
		MODE_NONE,
		MODE_TICK,
		MODE_ADD,
		MODE_OUT,
		MODE_IN
	} mode_t;

	typedef struct packed {
		logic        vld;
		logic [1:0]  prot;
		logic [31:0] iaddr;
		logic [15:0] iid;
		logic [31:0] eaddr;
		logic [15:0] eid;
		logic [32:0] expiry;
	} entry_t;

	typedef struct packed {
		logic clr;
		logic load;
		logic scan;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic cnt_last;
	} sts_t;

	function automatic logic [1:0] proto_code(input logic [7:0] p);
		logic [1:0] c;
		c = PC_UNK;
		if (p == PNUM_ICMP) c = PC_ICMP;
		else if (p == PNUM_UDP) c = PC_UDP;
		else if (p == PNUM_TCP) c = PC_TCP;
		return c;
	endfunction

endpackage

FILE: rtl/core/napt_ctrl.sv
// ----------------------------------------------------------------------------
// napt_ctrl
// Sequencer: clearing pass, item accept, table scan, finish, result hold.
// ----------------------------------------------------------------------------
module napt_ctrl import napt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FIN,
		S_OUT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	assign in_ready   = in_ready_q;
	assign out_valid  = out_valid_q;
	assign cmd.clr    = (state_q == S_CLEAR);
	assign cmd.load   = in_valid && in_ready_q;
	assign cmd.scan   = (state_q == S_SCAN);
	assign cmd.finish = (state_q == S_FIN);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			in_ready_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (sts.cnt_last) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q    <= S_SCAN;
						in_ready_q <= 1'b0;
					end
				end
				S_SCAN: begin
					if (sts.cnt_last) state_q <= S_DRAIN;
				end
				S_DRAIN: state_q <= S_FIN;
				S_FIN: begin
					state_q     <= S_OUT;
					out_valid_q <= 1'b1;
				end
				S_OUT: begin
					if (out_ready) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b0;
						in_ready_q  <= 1'b1;
					end
				end
				default: state_q <= S_CLEAR;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clr, cmd.load, cmd.scan, cmd.finish}))
		else $error("more than one datapath command");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("accepting while a result is pending");
	a_load_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.scan)
		else $error("accepted beat did not start a scan");
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("finish did not present a result");
`endif

endmodule

FILE: rtl/core/napt_dp.sv
// ----------------------------------------------------------------------------
// napt_dp
// Datapath: entry memory, scan compare stage, config, clock and result regs.
// ----------------------------------------------------------------------------
module napt_dp import napt_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output sts_t        sts,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [1:0]  func,
	input  logic [7:0]  proto,
	input  logic [31:0] query_addr,
	input  logic [15:0] query_id,
	input  logic [31:0] ext_addr,
	input  logic [15:0] ext_id,
	input  logic        no_expiry,
	output logic [2:0]  status,
	output logic [31:0] xlat_addr,
	output logic [15:0] mapped_id,
	output logic        created,
	output logic [6:0]  removed_count
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

	entry_t mem [TABLE_DEPTH];

	logic [15:0]   exp_sec_q;
	logic [2:0]    enable_q;
	logic [31:0]   seconds_q;
	logic [AW-1:0] cnt_q;

	mode_t       mode_q;
	logic [2:0]  pre_status_q;
	logic [1:0]  pc_q;
	logic [31:0] qaddr_q;
	logic [15:0] qid_q;
	logic [31:0] eaddr_q;
	logic [15:0] eid_q;
	logic        noexp_q;

	logic          rd_vld_s1;
	logic [AW-1:0] idx_s1;
	entry_t        rdata_s1;

	logic          hit_q;
	logic [AW-1:0] hit_idx_q;
	entry_t        hit_word_q;
	logic          free_q;
	logic [AW-1:0] free_idx_q;
	logic [CW-1:0] removed_q;

	logic          kill;
	logic          match;
	logic          is_free;
	logic          we;
	logic [AW-1:0] waddr;
	entry_t        wdata;
	logic [32:0]   new_exp;
	logic [1:0]    pc_in;
	entry_t        ins_word;

	logic [2:0]    fin_status;
	logic [31:0]   fin_addr;
	logic [15:0]   fin_id;
	logic          fin_created;

	assign sts.cnt_last = (cnt_q == LAST);
	assign new_exp = {1'b0, seconds_q} + {17'b0, exp_sec_q};
	assign pc_in   = proto_code(proto);

	always_comb begin
		ins_word.vld    = 1'b1;
		ins_word.prot   = pc_q;
		ins_word.iaddr  = qaddr_q;
		ins_word.iid    = qid_q;
		ins_word.eaddr  = eaddr_q;
		ins_word.eid    = eid_q;
		ins_word.expiry = (mode_q == MODE_ADD && noexp_q) ? 33'd0 : new_exp;
	end

	// per-entry compare on the registered read word
	always_comb begin
		kill    = 1'b0;
		match   = 1'b0;
		is_free = !rdata_s1.vld;
		unique case (mode_q)
			MODE_TICK: kill = rdata_s1.vld && (rdata_s1.expiry != 33'd0) &&
				(rdata_s1.expiry < {1'b0, seconds_q});
			MODE_ADD: begin
				kill = rdata_s1.vld && (rdata_s1.prot == pc_q) &&
					((rdata_s1.eaddr == eaddr_q && rdata_s1.eid == eid_q) ||
					 (rdata_s1.iaddr == qaddr_q && rdata_s1.iid == qid_q));
				is_free = !rdata_s1.vld || kill;
			end
			MODE_OUT: match = rdata_s1.vld && (rdata_s1.prot == pc_q) &&
				rdata_s1.iaddr == qaddr_q && rdata_s1.iid == qid_q;
			MODE_IN: match = rdata_s1.vld && (rdata_s1.prot == pc_q) &&
				rdata_s1.eaddr == qaddr_q && rdata_s1.eid == qid_q;
			default: ;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = idx_s1;
		wdata = rdata_s1;
		wdata.vld = 1'b0;
		if (cmd.clr) begin
			we    = 1'b1;
			waddr = cnt_q;
			wdata = '0;
		end else if (rd_vld_s1 && kill) begin
			we = 1'b1;
		end else if (cmd.finish) begin
			if ((mode_q == MODE_OUT || mode_q == MODE_IN) && hit_q) begin
				we    = 1'b1;
				waddr = hit_idx_q;
				wdata = hit_word_q;
				if (hit_word_q.expiry != 33'd0) wdata.expiry = new_exp;
			end else if ((mode_q == MODE_OUT || mode_q == MODE_ADD) && free_q) begin
				we    = 1'b1;
				waddr = free_idx_q;
				wdata = ins_word;
			end
		end
	end

	// result of the finished item
	always_comb begin
		fin_status  = pre_status_q;
		fin_addr    = '0;
		fin_id      = '0;
		fin_created = 1'b0;
		unique case (mode_q)
			MODE_NONE: fin_status = pre_status_q;
			MODE_TICK: fin_status = ST_DONE;
			MODE_ADD:  fin_status = free_q ? ST_DONE : ST_FULL;
			MODE_OUT: begin
				if (hit_q) begin
					fin_status = ST_TRANSLATED;
					fin_addr   = hit_word_q.eaddr;
					fin_id     = hit_word_q.eid;
				end else if (free_q) begin
					fin_status  = ST_TRANSLATED;
					fin_addr    = eaddr_q;
					fin_id      = eid_q;
					fin_created = 1'b1;
				end else begin
					fin_status = ST_FULL;
				end
			end
			MODE_IN: begin
				if (hit_q) begin
					fin_status = ST_TRANSLATED;
					fin_addr   = hit_word_q.iaddr;
					fin_id     = hit_word_q.iid;
				end else begin
					fin_status = ST_NOT_FOUND;
				end
			end
			default: fin_status = pre_status_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (cmd.scan) rdata_s1 <= mem[cnt_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_sec_q    <= 16'd60;
			enable_q     <= 3'd1;
			seconds_q    <= '0;
			cnt_q        <= '0;
			rd_vld_s1    <= 1'b0;
			mode_q       <= MODE_NONE;
			pre_status_q <= ST_PASSED;
			hit_q        <= 1'b0;
			free_q       <= 1'b0;
			removed_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_EXPIRE: exp_sec_q <= cfg_data;
					CFG_ENABLE: enable_q  <= cfg_data[2:0];
					default: ;
				endcase
			end
			rd_vld_s1 <= cmd.scan;
			if (cmd.clr || cmd.scan) cnt_q <= sts.cnt_last ? '0 : cnt_q + 1'b1;
			if (cmd.load) begin
				cnt_q     <= '0;
				hit_q     <= 1'b0;
				free_q    <= 1'b0;
				removed_q <= '0;
				if (func == FUNC_TICK) begin
					mode_q    <= MODE_TICK;
					seconds_q <= seconds_q + 32'd1;
				end else if (pc_in == PC_UNK) begin
					mode_q       <= MODE_NONE;
					pre_status_q <= ST_UNSUPP;
				end else if (func == FUNC_ADD) begin
					mode_q <= MODE_ADD;
				end else if (!enable_q[pc_in]) begin
					mode_q       <= MODE_NONE;
					pre_status_q <= ST_PASSED;
				end else begin
					mode_q <= (func == FUNC_OUT) ? MODE_OUT : MODE_IN;
				end
			end
			if (rd_vld_s1) begin
				if (kill) removed_q <= removed_q + 1'b1;
				if (match && !hit_q) hit_q <= 1'b1;
				if (is_free && !free_q) free_q <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.scan) idx_s1 <= cnt_q;
		if (cmd.load) begin
			pc_q    <= pc_in;
			qaddr_q <= query_addr;
			qid_q   <= query_id;
			eaddr_q <= ext_addr;
			eid_q   <= ext_id;
			noexp_q <= no_expiry;
		end
		if (rd_vld_s1 && match && !hit_q) begin
			hit_idx_q  <= idx_s1;
			hit_word_q <= rdata_s1;
		end
		if (rd_vld_s1 && is_free && !free_q) free_idx_q <= idx_s1;
		if (cmd.finish) begin
			status        <= fin_status;
			xlat_addr     <= fin_addr;
			mapped_id     <= fin_id;
			created       <= fin_created;
			removed_count <= 7'(removed_q);
		end
	end

endmodule

FILE: rtl/core/napt_translation_table.sv
// ----------------------------------------------------------------------------
// napt_translation_table
// IPv4 address-and-port translation table with expiry sweep and static adds.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) takes one beat per item: func selects
//    outbound translate, inbound translate, one-second tick or static add.
//  - Output channel (out_valid/out_ready) returns exactly one result beat per
//    item: status, mapped tuple, created flag and removed count.
//  - Config channel (cfg_valid/cfg_ready) writes expire_seconds (index 0) or
//    protocol_enable (index 1); always ready, write only while idle.
//  - Every item walks the whole entry memory, one entry per cycle through
//    its single read port; the result is valid after the scan, one compare
//    stage and the finish state.
//  - The result stays on the output until taken; the next item is accepted
//    after the result beat completes.
//  - After reset a clearing pass invalidates every entry; in_ready stays
//    low during it. Config writes are taken meanwhile.
// ----------------------------------------------------------------------------
module napt_translation_table import napt_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  func,
	input  logic [7:0]  proto,
	input  logic [31:0] query_addr,
	input  logic [15:0] query_id,
	input  logic [31:0] ext_addr,
	input  logic [15:0] ext_id,
	input  logic        no_expiry,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [31:0] xlat_addr,
	output logic [15:0] mapped_id,
	output logic        created,
	output logic [6:0]  removed_count,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	// config beats land directly in the datapath registers
	assign cfg_ready = 1'b1;

	napt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	napt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.func          (func),
		.proto         (proto),
		.query_addr    (query_addr),
		.query_id      (query_id),
		.ext_addr      (ext_addr),
		.ext_id        (ext_id),
		.no_expiry     (no_expiry),
		.status        (status),
		.xlat_addr     (xlat_addr),
		.mapped_id     (mapped_id),
		.created       (created),
		.removed_count (removed_count)
	);

endmodule
